### rtl/ecc_pkg.sv
`timescale 1ns / 1ps

package ecc_pkg;

    // Input operation codes
    localparam logic       OP_PRESS = 1'b0;
    localparam logic       OP_TICK  = 1'b1;

    // Button kinds
    localparam logic [1:0] BTN_CAR       = 2'd0;
    localparam logic [1:0] BTN_HALL_UP   = 2'd1;
    localparam logic [1:0] BTN_HALL_DOWN = 2'd2;

    // Request kind held at each floor
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_CAR  = 2'd1;
    localparam logic [1:0] KIND_HALL = 2'd2;

    // Hall direction held at each floor
    localparam logic [1:0] HALL_UP   = 2'd0;
    localparam logic [1:0] HALL_DOWN = 2'd1;
    localparam logic [1:0] HALL_BOTH = 2'd2;
    localparam logic [1:0] HALL_NO   = 2'd3;

    // Car status
    localparam logic [1:0] ST_OPEN   = 2'd0;
    localparam logic [1:0] ST_CLOSED = 2'd1;
    localparam logic [1:0] ST_RUN    = 2'd2;
    localparam logic [1:0] ST_STOP   = 2'd3;

    // Travel direction
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_STILL = 2'd2;

    // Commands from the controller to one floor cell
    localparam logic [2:0] CELL_NOP       = 3'd0;
    localparam logic [2:0] CELL_CLEAR     = 3'd1;
    localparam logic [2:0] CELL_CAR       = 3'd2;
    localparam logic [2:0] CELL_HALL_UP   = 3'd3;
    localparam logic [2:0] CELL_HALL_DOWN = 3'd4;
    localparam logic [2:0] CELL_SET_DOWN  = 3'd5;
    localparam logic [2:0] CELL_SET_UP    = 3'd6;

    typedef struct packed {
        logic       operation;
        logic [1:0] button_kind;
        logic [2:0] button_floor;
    } item_t;

    typedef struct packed {
        logic [2:0] car_floor;
        logic [1:0] car_status;
        logic [1:0] travel_direction;
    } result_t;

    // Pending-request flags: any request, any not hall-down only, any not hall-up only
    typedef struct packed {
        logic any;
        logic not_down;
        logic not_up;
    } scan_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] hall;
        scan_t      own;
        scan_t      above;
        scan_t      below;
    } cell_view_t;

    function automatic scan_t scan_or(input scan_t a, input scan_t b);
        scan_t r;
        r.any      = a.any | b.any;
        r.not_down = a.not_down | b.not_down;
        r.not_up   = a.not_up | b.not_up;
        return r;
    endfunction

endpackage

### rtl/ecc_cell.sv
`timescale 1ns / 1ps

module ecc_cell
    import ecc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [2:0] op,
    input  scan_t      from_above,
    input  scan_t      from_below,
    output scan_t      to_above,
    output scan_t      to_below,
    output cell_view_t view
);

    logic [1:0] kind_reg, kind_next;
    logic [1:0] hall_reg, hall_next;
    scan_t      above_reg;
    scan_t      below_reg;
    scan_t      own;

    always_comb
    begin
        kind_next = kind_reg;
        hall_next = hall_reg;
        unique case (op)
            CELL_CLEAR:
            begin
                kind_next = KIND_NONE;
                hall_next = HALL_NO;
            end
            CELL_CAR:
            begin
                kind_next = KIND_CAR;
            end
            CELL_HALL_UP:
            begin
                kind_next = KIND_HALL;
                hall_next = (hall_reg == HALL_DOWN || hall_reg == HALL_BOTH) ? HALL_BOTH
                                                                             : HALL_UP;
            end
            CELL_HALL_DOWN:
            begin
                kind_next = KIND_HALL;
                hall_next = (hall_reg == HALL_UP || hall_reg == HALL_BOTH) ? HALL_BOTH
                                                                           : HALL_DOWN;
            end
            CELL_SET_DOWN: hall_next = HALL_DOWN;
            CELL_SET_UP:   hall_next = HALL_UP;
            default:       ;
        endcase
    end

    assign own.any      = (kind_reg != KIND_NONE);
    assign own.not_down = (kind_reg != KIND_NONE) && (hall_reg != HALL_DOWN);
    assign own.not_up   = (kind_reg != KIND_NONE) && (hall_reg != HALL_UP);

    // Each cell summarises everything beyond it; the summaries ripple one floor a cycle.
    assign to_below = scan_or(own, above_reg);
    assign to_above = scan_or(own, below_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_NONE;
            hall_reg  <= HALL_NO;
            above_reg <= '0;
            below_reg <= '0;
        end
        else
        begin
            kind_reg  <= kind_next;
            hall_reg  <= hall_next;
            above_reg <= from_above;
            below_reg <= from_below;
        end
    end

    assign view.kind  = kind_reg;
    assign view.hall  = hall_reg;
    assign view.own   = own;
    assign view.above = above_reg;
    assign view.below = below_reg;

endmodule

### rtl/elevator_collective_controller.sv
`timescale 1ns / 1ps
// A transaction is taken while idle, executed in SEQ_EXEC, then held in SEQ_SETTLE while the
// request summaries ripple through the row of floor cells one floor per cycle; the result
// strobe follows SEQ_SETTLE. No transaction is taken while busy; start may be raised again in
// the cycle of the strobe. The receiver cannot stall.
// Reset: asynchronous, active low; all floors clear, car at floor 0, stopped, still.
module elevator_collective_controller
    import ecc_pkg::*;
#(
    parameter int NUM_FLOORS = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam int FW = $clog2(NUM_FLOORS);

    localparam logic [1:0] SEQ_IDLE   = 2'd0;
    localparam logic [1:0] SEQ_EXEC   = 2'd1;
    localparam logic [1:0] SEQ_SETTLE = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [FW-1:0] cnt_reg, cnt_next;
    item_t         item_reg;
    logic [FW-1:0] floor_reg, floor_next;
    logic [1:0]    status_reg, status_next;
    logic [1:0]    direction_reg, direction_next;
    logic          done_reg;
    result_t       result_reg;

    cell_view_t    views [NUM_FLOORS];
    scan_t         up_link [NUM_FLOORS];
    scan_t         down_link [NUM_FLOORS];
    logic [2:0]    press_op;
    logic [2:0]    tick_op;
    cell_view_t    cur;
    logic          here;
    logic          accept;

    assign accept = start && !busy;
    assign busy   = (state_reg != SEQ_IDLE);

    genvar gi;
    generate
        for (gi = 0; gi < NUM_FLOORS; gi++)
        begin : g_cell
            logic [2:0] cell_op;
            scan_t      from_above;
            scan_t      from_below;

            assign from_above = (gi == NUM_FLOORS - 1) ? scan_t'('0) : down_link[gi + 1];
            assign from_below = (gi == 0) ? scan_t'('0) : up_link[gi - 1];

            always_comb
            begin
                cell_op = CELL_NOP;
                if (state_reg == SEQ_EXEC)
                begin
                    if (item_reg.operation == OP_TICK)
                    begin
                        if (floor_reg == FW'(gi))
                            cell_op = tick_op;
                    end
                    else if (int'(item_reg.button_floor) == gi)
                    begin
                        cell_op = press_op;
                    end
                end
            end

            ecc_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (cell_op),
                .from_above (from_above),
                .from_below (from_below),
                .to_above   (up_link[gi]),
                .to_below   (down_link[gi]),
                .view       (views[gi])
            );
        end
    endgenerate

    always_comb
    begin
        unique case (item_reg.button_kind)
            BTN_CAR:       press_op = CELL_CAR;
            BTN_HALL_UP:   press_op = CELL_HALL_UP;
            BTN_HALL_DOWN: press_op = CELL_HALL_DOWN;
            default:       press_op = CELL_NOP;
        endcase
    end

    assign cur  = views[floor_reg];
    assign here = cur.own.any;

    // Tick rules, evaluated against summaries that have fully settled.
    always_comb
    begin
        floor_next     = floor_reg;
        status_next    = status_reg;
        direction_next = direction_reg;
        tick_op        = CELL_NOP;
        unique case (status_reg)
            ST_STOP:
            begin
                if (here)
                begin
                    tick_op     = CELL_CLEAR;
                    status_next = ST_OPEN;
                end
                else if (cur.above.any)
                begin
                    direction_next = DIR_UP;
                    status_next    = ST_RUN;
                end
                else if (cur.below.any)
                begin
                    direction_next = DIR_DOWN;
                    status_next    = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (direction_reg == DIR_UP)
                begin
                    if (here && cur.hall != HALL_DOWN)
                        status_next = ST_OPEN;
                    else if (cur.above.any)
                        floor_next = floor_reg + 1'b1;
                    else if (here)
                        status_next = ST_OPEN;
                    else if (cur.below.any)
                        direction_next = DIR_DOWN;
                end
                else
                begin
                    // Running with no direction behaves as running down.
                    if (here && cur.hall != HALL_UP)
                        status_next = ST_OPEN;
                    else if (cur.below.any)
                        floor_next = floor_reg - 1'b1;
                    else if (here)
                        status_next = ST_OPEN;
                    else if (cur.above.any)
                        direction_next = DIR_UP;
                end
            end
            ST_OPEN:
            begin
                status_next = ST_CLOSED;
                if (direction_reg == DIR_UP)
                begin
                    if (cur.kind == KIND_HALL && cur.hall == HALL_BOTH)
                        tick_op = CELL_SET_DOWN;
                    else if (here)
                        tick_op = CELL_CLEAR;
                end
                else if (direction_reg == DIR_DOWN)
                begin
                    if (cur.kind == KIND_HALL && cur.hall == HALL_BOTH)
                        tick_op = CELL_SET_UP;
                    else if (here)
                        tick_op = CELL_CLEAR;
                end
                else
                begin
                    tick_op = CELL_CLEAR;
                end
            end
            default:
            begin
                if (direction_reg == DIR_UP)
                begin
                    if (cur.own.not_down || cur.above.not_down)
                    begin
                        status_next = ST_RUN;
                    end
                    else if (cur.below.not_up)
                    begin
                        status_next    = ST_RUN;
                        direction_next = DIR_DOWN;
                    end
                    else
                    begin
                        status_next    = ST_STOP;
                        direction_next = DIR_STILL;
                    end
                end
                else
                begin
                    if (cur.below.not_up)
                    begin
                        status_next = ST_RUN;
                    end
                    else if (cur.own.not_down || cur.above.not_down)
                    begin
                        status_next    = ST_RUN;
                        direction_next = DIR_UP;
                    end
                    else
                    begin
                        status_next    = ST_STOP;
                        direction_next = DIR_STILL;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                    state_next = SEQ_EXEC;
            end
            SEQ_EXEC:
            begin
                cnt_next   = '0;
                state_next = SEQ_SETTLE;
            end
            SEQ_SETTLE:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == FW'(NUM_FLOORS - 2))
                    state_next = SEQ_IDLE;
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            cnt_reg       <= '0;
            floor_reg     <= '0;
            status_reg    <= ST_STOP;
            direction_reg <= DIR_STILL;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= (state_reg == SEQ_SETTLE) && (state_next == SEQ_IDLE);
            if (state_reg == SEQ_EXEC && item_reg.operation == OP_TICK)
            begin
                floor_reg     <= floor_next;
                status_reg    <= status_next;
                direction_reg <= direction_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
        if (state_reg == SEQ_SETTLE)
        begin
            result_reg.car_floor        <= 3'(floor_reg);
            result_reg.car_status       <= status_reg;
            result_reg.travel_direction <= direction_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_when_free : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a transaction is still in progress");

    a_floor_range : assert property (@(posedge clk) disable iff (!rst_n)
        int'(floor_reg) < NUM_FLOORS)
        else $error("car floor beyond the top floor");

    a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy && !done)
        else $error("accepted transaction did not make the controller busy");

    a_done_after_settle : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == SEQ_SETTLE))
        else $error("result strobe without a completed settle phase");

endmodule
